@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RICT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RICT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RICT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RICT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RICT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RICT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/rict_pkg.sv @@
// types, constants and helpers of the rgba image compare block
`default_nettype none
package rict_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W = 13;
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int CNT_W = 25;
	localparam int CH_W = 8;
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int IDX_W = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CH_W-1:0] CH_FULL = {CH_W{1'b1}};

	typedef enum logic [IDX_W-1:0] {
		REG_ACTUAL_WIDTH    = 3'd0,
		REG_ACTUAL_HEIGHT   = 3'd1,
		REG_EXPECTED_WIDTH  = 3'd2,
		REG_EXPECTED_HEIGHT = 3'd3,
		REG_TOLERANCE       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] aw;
		logic [DIM_W-1:0] ah;
		logic [DIM_W-1:0] ew;
		logic [DIM_W-1:0] eh;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
		logic [CH_W-1:0]  tol;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] ar;
		logic [CH_W-1:0] ag;
		logic [CH_W-1:0] ab;
		logic [CH_W-1:0] aa;
		logic [CH_W-1:0] er;
		logic [CH_W-1:0] eg;
		logic [CH_W-1:0] eb;
		logic [CH_W-1:0] ea;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
		logic            miss;
	} diff_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		res = v;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			res = DIM_W'(MAX_DIM);
		end
		return res;
	endfunction

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] x,
		input logic [CH_W-1:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

endpackage
`default_nettype wire

@@ hdl/rict_if.sv @@
// stream interfaces for pixel items and result items
`default_nettype none
interface rict_pix_if;
	import rict_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] actual_red;
	logic [CH_W-1:0] actual_green;
	logic [CH_W-1:0] actual_blue;
	logic [CH_W-1:0] actual_alpha;
	logic [CH_W-1:0] expected_red;
	logic [CH_W-1:0] expected_green;
	logic [CH_W-1:0] expected_blue;
	logic [CH_W-1:0] expected_alpha;

	modport source (
		output valid, actual_red, actual_green, actual_blue, actual_alpha,
		output expected_red, expected_green, expected_blue, expected_alpha,
		input  ready
	);
	modport sink (
		input  valid, actual_red, actual_green, actual_blue, actual_alpha,
		input  expected_red, expected_green, expected_blue, expected_alpha,
		output ready
	);
endinterface

interface rict_res_if;
	import rict_pkg::*;
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  diff_red;
	logic [CH_W-1:0]  diff_green;
	logic [CH_W-1:0]  diff_blue;
	logic [CH_W-1:0]  diff_alpha;
	logic             mismatch;
	logic [CNT_W-1:0] miss_count;
	logic             last_pixel;

	modport source (
		output valid, diff_red, diff_green, diff_blue, diff_alpha,
		output mismatch, miss_count, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, diff_red, diff_green, diff_blue, diff_alpha,
		input  mismatch, miss_count, last_pixel,
		output ready
	);
endinterface
`default_nettype wire

@@ hdl/rict_apb_regs.sv @@
// apb configuration registers with clamped image and raster dimensions
`default_nettype none
module rict_apb_regs
	import rict_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [DIM_W-1:0] act_w_q, act_h_q, exp_w_q, exp_h_q;
	logic [CH_W-1:0]  tol_q;
	logic             wr_en;
	reg_idx_t         idx;
	logic [DIM_W-1:0] aw, ah, ew, eh;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_w_q <= DIM_W'(1);
			act_h_q <= DIM_W'(1);
			exp_w_q <= DIM_W'(1);
			exp_h_q <= DIM_W'(1);
			tol_q   <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ACTUAL_WIDTH:    act_w_q <= pwdata[DIM_W-1:0];
				REG_ACTUAL_HEIGHT:   act_h_q <= pwdata[DIM_W-1:0];
				REG_EXPECTED_WIDTH:  exp_w_q <= pwdata[DIM_W-1:0];
				REG_EXPECTED_HEIGHT: exp_h_q <= pwdata[DIM_W-1:0];
				REG_TOLERANCE:       tol_q   <= pwdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ACTUAL_WIDTH:    prdata = APB_DW'(act_w_q);
			REG_ACTUAL_HEIGHT:   prdata = APB_DW'(act_h_q);
			REG_EXPECTED_WIDTH:  prdata = APB_DW'(exp_w_q);
			REG_EXPECTED_HEIGHT: prdata = APB_DW'(exp_h_q);
			REG_TOLERANCE:       prdata = APB_DW'(tol_q);
			default:             prdata = '0;
		endcase
	end

	assign aw = clamp_dim(act_w_q);
	assign ah = clamp_dim(act_h_q);
	assign ew = clamp_dim(exp_w_q);
	assign eh = clamp_dim(exp_h_q);

	always_comb begin
		cfg.aw  = aw;
		cfg.ah  = ah;
		cfg.ew  = ew;
		cfg.eh  = eh;
		cfg.dw  = (aw > ew) ? aw : ew;
		cfg.dh  = (ah > eh) ? ah : eh;
		cfg.tol = tol_q;
	end

endmodule
`default_nettype wire

@@ hdl/rict_pixel_cmp.sv @@
// per-pixel channel differences, tolerance check and diff pixel
`default_nettype none
module rict_pixel_cmp
	import rict_pkg::*;
(
	input  wire pix_t             pix,
	input  wire logic             oob,
	input  wire logic [CH_W-1:0]  tol,
	output diff_t                 diff
);

	logic [CH_W-1:0] dr, dg, db, da, m_rg, m_ba, m_all;
	logic            over;

	assign dr    = abs_diff(pix.ar, pix.er);
	assign dg    = abs_diff(pix.ag, pix.eg);
	assign db    = abs_diff(pix.ab, pix.eb);
	assign da    = abs_diff(pix.aa, pix.ea);
	assign m_rg  = (dr > dg) ? dr : dg;
	assign m_ba  = (db > da) ? db : da;
	assign m_all = (m_rg > m_ba) ? m_rg : m_ba;
	assign over  = m_all > tol;

	always_comb begin
		if (oob) begin
			diff.r    = CH_FULL;
			diff.g    = '0;
			diff.b    = CH_FULL;
			diff.a    = CH_FULL;
			diff.miss = 1'b1;
		end else if (over) begin
			diff.r    = dr;
			diff.g    = dg;
			diff.b    = db;
			diff.a    = CH_FULL;
			diff.miss = 1'b1;
		end else begin
			diff.r    = '0;
			diff.g    = '0;
			diff.b    = '0;
			diff.a    = '0;
			diff.miss = 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ hdl/rgba_image_compare_tolerance.sv @@
// rgba image compare with tolerance: scan position, compare stage, result register
// an accepted item passes stage one and then the result register, where res.ready can stall it
// throughput: one item per cycle while the result side is not stalled, set by the two-stage valid/ready pipeline
// the scan position is taken when the item is accepted, the count when it leaves stage one
// reset clears scan position, mismatch count, pipeline valids and sets the registers
// to widths and heights of 1 and tolerance 0
`default_nettype none
`include "assert_macros.svh"
module rgba_image_compare_tolerance
	import rict_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	rict_pix_if.sink               pix,
	rict_res_if.source             res
);

	cfg_t             cfg;
	logic [POS_W-1:0] col_q, row_q;
	logic [CNT_W-1:0] total_q;
	logic [DIM_W-1:0] c0, r0, c_inc, nxt_col, nxt_row;
	logic             restart, oob, last;
	logic             accept, adv_s1, ready_s1;

	logic             valid_s1;
	pix_t             pix_s1;
	logic             oob_s1, restart_s1, last_s1;

	pix_t             pix_in;
	diff_t            diff;
	logic [CNT_W-1:0] cnt_base, cnt_new;

	logic             res_valid_q;
	diff_t            res_diff_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic             res_last_q;

	rict_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign ready_s1  = !res_valid_q || res.ready;
	assign adv_s1    = valid_s1 && ready_s1;
	assign pix.ready = !valid_s1 || ready_s1;
	assign accept    = pix.valid && pix.ready;

	// scan position for the item at the input
	always_comb begin
		c0      = DIM_W'(col_q);
		r0      = DIM_W'(row_q);
		restart = 1'b0;
		if (c0 >= cfg.dw) begin
			c0 = '0;
			r0 = DIM_W'(row_q) + DIM_W'(1);
		end
		if (r0 >= cfg.dh) begin
			r0      = '0;
			c0      = '0;
			restart = 1'b1;
		end
		oob   = (c0 >= cfg.aw) || (r0 >= cfg.ah) || (c0 >= cfg.ew) || (r0 >= cfg.eh);
		last  = (c0 == cfg.dw - DIM_W'(1)) && (r0 == cfg.dh - DIM_W'(1));
		c_inc = c0 + DIM_W'(1);
		if (last) begin
			nxt_col = '0;
			nxt_row = '0;
		end else if (c_inc >= cfg.dw) begin
			nxt_col = '0;
			nxt_row = r0 + DIM_W'(1);
		end else begin
			nxt_col = c_inc;
			nxt_row = r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= nxt_col[POS_W-1:0];
			row_q <= nxt_row[POS_W-1:0];
		end
	end

	// input stage
	always_comb begin
		pix_in.ar = pix.actual_red;
		pix_in.ag = pix.actual_green;
		pix_in.ab = pix.actual_blue;
		pix_in.aa = pix.actual_alpha;
		pix_in.er = pix.expected_red;
		pix_in.eg = pix.expected_green;
		pix_in.eb = pix.expected_blue;
		pix_in.ea = pix.expected_alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_in;
			oob_s1     <= oob;
			restart_s1 <= restart;
			last_s1    <= last;
		end
	end

	// compare and count
	rict_pixel_cmp u_cmp (
		.pix  (pix_s1),
		.oob  (oob_s1),
		.tol  (cfg.tol),
		.diff (diff)
	);

	assign cnt_base = restart_s1 ? '0 : total_q;
	assign cnt_new  = (diff.miss && (cnt_base != COUNT_MAX)) ? cnt_base + CNT_W'(1) : cnt_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				total_q <= last_s1 ? '0 : cnt_new;
			end
			if (ready_s1) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_diff_q <= diff;
			res_cnt_q  <= cnt_new;
			res_last_q <= last_s1;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.diff_red   = res_diff_q.r;
	assign res.diff_green = res_diff_q.g;
	assign res.diff_blue  = res_diff_q.b;
	assign res.diff_alpha = res_diff_q.a;
	assign res.mismatch   = res_diff_q.miss;
	assign res.miss_count = res_cnt_q;
	assign res.last_pixel = res_last_q;

	`RICT_ASSERT_IMP(a_miss_alpha, clk, arst_n, res_valid_q && res_diff_q.miss, res_diff_q.a == CH_FULL, "mismatch item without full alpha")
	`RICT_ASSERT_IMP(a_match_zero, clk, arst_n, res_valid_q && !res_diff_q.miss, res_diff_q == '0, "matching item with nonzero diff pixel")
	`RICT_ASSERT_IMP(a_miss_count, clk, arst_n, res_valid_q && res_diff_q.miss, res_cnt_q != '0, "mismatch item with zero count")
	`RICT_ASSERT_NXT(a_frame_clear, clk, arst_n, adv_s1 && last_s1, total_q == '0, "count not cleared after last item of frame")

endmodule
`default_nettype wire

@@ dv/rgba_image_compare_tolerance_tb.sv @@
// testbench for rgba_image_compare_tolerance: pixel stream against a scan-order predictor
`timescale 1ns / 100ps
module rgba_image_compare_tolerance_tb;
	import rict_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic [CH_W-1:0]  a;
		logic             miss;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} diff_item_t;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [31:0] val;
		pix_t        px;
		bit          typed;
		diff_item_t  want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rict_pix_if pix_bus ();
	rict_res_if res_bus ();

	rgba_image_compare_tolerance uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_bus),
		.res     (res_bus)
	);

	// predictor copy of registers and scan state
	logic [DIM_W-1:0] cfg_aw = 1;
	logic [DIM_W-1:0] cfg_ah = 1;
	logic [DIM_W-1:0] cfg_ew = 1;
	logic [DIM_W-1:0] cfg_eh = 1;
	logic [CH_W-1:0]  cfg_tol = 0;
	int scan_col = 0;
	int scan_row = 0;
	int frame_misses = 0;

	diff_item_t expected_diffs[$];
	plan_row_t  plan[$];

	int fail_count = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	int frames_done = 0;
	int misses_seen = 0;
	int reg_writes = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int fit_dim(logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	function automatic int chan_gap(logic [CH_W-1:0] x, logic [CH_W-1:0] y);
		int xi;
		int yi;
		xi = x;
		yi = y;
		return (xi > yi) ? xi - yi : yi - xi;
	endfunction

	function automatic diff_item_t predict_diff(pix_t p);
		int aw, ah, ew, eh, dw, dh;
		int gr, gg, gb, ga, peak;
		diff_item_t d;
		aw = fit_dim(cfg_aw);
		ah = fit_dim(cfg_ah);
		ew = fit_dim(cfg_ew);
		eh = fit_dim(cfg_eh);
		dw = (aw > ew) ? aw : ew;
		dh = (ah > eh) ? ah : eh;
		d = '0;
		// raster shrank since the last item
		if (scan_col >= dw) begin
			scan_col = 0;
			scan_row++;
		end
		if (scan_row >= dh) begin
			scan_row = 0;
			scan_col = 0;
			frame_misses = 0;
		end
		if (scan_col >= aw || scan_row >= ah || scan_col >= ew || scan_row >= eh) begin
			d.r = CH_FULL;
			d.b = CH_FULL;
			d.a = CH_FULL;
			d.miss = 1'b1;
		end else begin
			gr = chan_gap(p.ar, p.er);
			gg = chan_gap(p.ag, p.eg);
			gb = chan_gap(p.ab, p.eb);
			ga = chan_gap(p.aa, p.ea);
			peak = gr;
			if (gg > peak) peak = gg;
			if (gb > peak) peak = gb;
			if (ga > peak) peak = ga;
			if (peak > int'(cfg_tol)) begin
				d.r = CH_W'(gr);
				d.g = CH_W'(gg);
				d.b = CH_W'(gb);
				d.a = CH_FULL;
				d.miss = 1'b1;
			end
		end
		if (d.miss && frame_misses < int'(COUNT_MAX)) begin
			frame_misses++;
		end
		d.cnt = CNT_W'(frame_misses);
		d.last = (scan_col == dw - 1) && (scan_row == dh - 1);
		if (d.last) begin
			scan_col = 0;
			scan_row = 0;
			frame_misses = 0;
		end else begin
			scan_col++;
			if (scan_col >= dw) begin
				scan_col = 0;
				scan_row++;
			end
		end
		return d;
	endfunction

	function automatic void add_cfg(reg_idx_t idx, logic [31:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		row.px = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void add_pix(pix_t p, bit typed, diff_item_t want);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx = REG_ACTUAL_WIDTH;
		row.val = '0;
		row.px = p;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	function automatic logic [31:0] pick_dim();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = MAX_DIM;
			2: v = $urandom_range(MAX_DIM + 1, 8191);
			3: v = $urandom_range(6, 64);
			default: v = $urandom_range(1, 5);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			v = v | ($urandom << DIM_W);
		end
		return v;
	endfunction

	function automatic logic [31:0] pick_tol();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 255;
			default: v = $urandom_range(0, 255);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			v = v | ($urandom << CH_W);
		end
		return v;
	endfunction

	function automatic logic [CH_W-1:0] near_channel(logic [CH_W-1:0] a, int tol);
		int av;
		int d;
		int v;
		av = a;
		d = $urandom_range(0, (tol + 1 > 255) ? 255 : tol + 1);
		v = $urandom_range(0, 1) ? av + d : av - d;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return CH_W'(v);
	endfunction

	function automatic pix_t make_pixel();
		pix_t p;
		p = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
			end
			1: begin
				p.er = p.ar;
				p.eg = p.ag;
				p.eb = p.ab;
				p.ea = p.aa;
			end
			default: begin
				p.er = near_channel(p.ar, cfg_tol);
				p.eg = near_channel(p.ag, cfg_tol);
				p.eb = near_channel(p.ab, cfg_tol);
				p.ea = near_channel(p.aa, cfg_tol);
			end
		endcase
		return p;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_pixel(pix_t p, bit typed, diff_item_t want);
		diff_item_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.actual_red <= p.ar;
		pix_bus.actual_green <= p.ag;
		pix_bus.actual_blue <= p.ab;
		pix_bus.actual_alpha <= p.aa;
		pix_bus.expected_red <= p.er;
		pix_bus.expected_green <= p.eg;
		pix_bus.expected_blue <= p.eb;
		pix_bus.expected_alpha <= p.ea;
		do @(posedge clk); while (!pix_bus.ready);
		predicted = predict_diff(p);
		expected_diffs.push_back(typed ? want : predicted);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic settle_block();
		pix_bus.valid <= 1'b0;
		wait (expected_diffs.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ACTUAL_WIDTH: cfg_aw = val[DIM_W-1:0];
			REG_ACTUAL_HEIGHT: cfg_ah = val[DIM_W-1:0];
			REG_EXPECTED_WIDTH: cfg_ew = val[DIM_W-1:0];
			REG_EXPECTED_HEIGHT: cfg_eh = val[DIM_W-1:0];
			REG_TOLERANCE: cfg_tol = val[CH_W-1:0];
			default: begin
			end
		endcase
		reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// result side: ready pattern, long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 60;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		diff_item_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (expected_diffs.size() == 0) begin
				$error("result item arrived with nothing expected");
				fail_count++;
			end else begin
				want = expected_diffs.pop_front();
				check_field("diff_red", want.r, res_bus.diff_red);
				check_field("diff_green", want.g, res_bus.diff_green);
				check_field("diff_blue", want.b, res_bus.diff_blue);
				check_field("diff_alpha", want.a, res_bus.diff_alpha);
				check_field("mismatch", want.miss, res_bus.mismatch);
				check_field("miss_count", want.cnt, res_bus.miss_count);
				check_field("last_pixel", want.last, res_bus.last_pixel);
				if (want.last) frames_done++;
				if (want.miss) misses_seen++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_bus.valid = 1'b0;
		pix_bus.actual_red = '0;
		pix_bus.actual_green = '0;
		pix_bus.actual_blue = '0;
		pix_bus.actual_alpha = '0;
		pix_bus.expected_red = '0;
		pix_bus.expected_green = '0;
		pix_bus.expected_blue = '0;
		pix_bus.expected_alpha = '0;
		res_bus.ready = 1'b0;

		// pixel words: actual rgba then expected rgba
		// 1x1 raster after reset, every item is a whole frame
		add_pix(64'h0000_0000_0000_0000, 1, {32'h0000_0000, 1'b0, 25'd0, 1'b1});
		add_pix(64'hFFFF_FFFF_0000_0000, 1, {32'hFFFF_FFFF, 1'b1, 25'd1, 1'b1});
		add_pix(64'h0000_0000_FFFF_FFFF, 1, {32'hFFFF_FFFF, 1'b1, 25'd1, 1'b1});
		add_pix(64'h5A5A_5A01_5A5A_5A00, 1, {32'h0000_00FF, 1'b1, 25'd1, 1'b1});
		add_pix(64'h55AA_55AA_55AA_55AA, 1, {32'h0000_0000, 1'b0, 25'd0, 1'b1});
		add_pix(64'h0100_0000_0000_0000, 1, {32'h0100_00FF, 1'b1, 25'd1, 1'b1});
		// 2x2 raster, only the corner lies in both images
		add_cfg(REG_ACTUAL_WIDTH, 32'd2);
		add_cfg(REG_EXPECTED_HEIGHT, 32'd2);
		add_cfg(REG_TOLERANCE, 32'hFF);
		add_pix(64'hFFFF_FFFF_0000_0000, 1, {32'h0000_0000, 1'b0, 25'd0, 1'b0});
		add_pix(64'h1234_5678_9ABC_DEF0, 1, {32'hFF00_FFFF, 1'b1, 25'd1, 1'b0});
		add_pix(64'h0000_0000_0000_0000, 1, {32'hFF00_FFFF, 1'b1, 25'd2, 1'b0});
		add_pix(64'hFFFF_FFFF_FFFF_FFFF, 1, {32'hFF00_FFFF, 1'b1, 25'd3, 1'b1});
		// zero width acts as one, oversized height as the maximum
		add_cfg(REG_TOLERANCE, 32'hFE);
		add_cfg(REG_ACTUAL_WIDTH, 32'hFFFF_E000);
		add_cfg(REG_ACTUAL_HEIGHT, 32'h0000_1FFF);
		add_pix(64'hFFFF_FFFF_0000_0000, 1, {32'hFFFF_FFFF, 1'b1, 25'd1, 1'b0});
		add_pix(64'h1020_3040_2010_4030, 0, '0);
		add_pix(64'h0102_0304_0102_0304, 0, '0);
		add_pix(64'h80FE_7F01_7F01_80FE, 0, '0);
		// widen mid-frame
		add_cfg(REG_EXPECTED_WIDTH, 32'd3);
		add_cfg(REG_EXPECTED_HEIGHT, 32'h0000_1FFF);
		add_cfg(REG_ACTUAL_WIDTH, 32'd4097);
		add_pix(64'hFF00_FF00_00FF_00FF, 0, '0);
		add_pix(64'h0000_0000_0000_00FF, 0, '0);
		add_pix(64'h7F7F_7F7F_8080_8080, 0, '0);
		add_pix(64'hAAAA_AAAA_5555_5555, 0, '0);
		// narrow mid-frame, column falls outside and wraps to the next row
		add_cfg(REG_EXPECTED_WIDTH, 32'd1);
		add_cfg(REG_ACTUAL_WIDTH, 32'd2);
		add_pix(64'h0F0F_0F0F_F0F0_F0F0, 0, '0);
		add_pix(64'h3333_3333_3333_3333, 0, '0);
		// shrink height mid-frame, new frame with cleared count
		add_cfg(REG_ACTUAL_HEIGHT, 32'd1);
		add_cfg(REG_EXPECTED_HEIGHT, 32'd1);
		add_cfg(REG_TOLERANCE, 32'd0);
		add_pix(64'hC3C3_C3C3_C3C3_C3C3, 0, '0);
		add_pix(64'h0000_0000_0000_0000, 0, '0);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle_block();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_pixel(plan[i].px, plan[i].typed, plan[i].want);
			end
		end

		// idle phases: none, sender, receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			for (int blk = 0; blk < 5; blk++) begin
				settle_block();
				case (ph)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct = 63;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 63;
					end
					default: begin
						send_idle_pct = 6;
						recv_stall_pct = 6;
					end
				endcase
				if (blk == 0 || $urandom_range(0, 1)) write_reg(REG_ACTUAL_WIDTH, pick_dim());
				if (blk == 0 || $urandom_range(0, 1)) write_reg(REG_ACTUAL_HEIGHT, pick_dim());
				if (blk == 0 || $urandom_range(0, 1)) write_reg(REG_EXPECTED_WIDTH, pick_dim());
				if (blk == 0 || $urandom_range(0, 1)) write_reg(REG_EXPECTED_HEIGHT, pick_dim());
				if (blk == 0 || $urandom_range(0, 1)) write_reg(REG_TOLERANCE, pick_tol());
				for (int k = 0; k < 40; k++) begin
					if (ph == 0 && blk == 1 && k == 5) begin
						hold_request = 1'b1;
					end
					if (ph == 2 && blk == 2 && k == 20) begin
						pix_bus.valid <= 1'b0;
						wait (expected_diffs.size() == 0);
						@(negedge clk);
					end
					send_pixel(make_pixel(), 1'b0, '0);
				end
			end
		end

		pix_bus.valid <= 1'b0;
		wait (expected_diffs.size() == 0);
		repeat (10) @(posedge clk);
		$display("covered %0d pixel items and %0d register writes under four idle patterns",
			pixels_sent, reg_writes);
		$display("checked %0d result items: %0d mismatching positions, %0d frames completed",
			results_seen, misses_seen, frames_done);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
